>>> rtl/ddto_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddto_pkg
// Shared types, constants and the glyph ROM of the decimal digit overlay.
// ----------------------------------------------------------------------------
package ddto_pkg;

    localparam int GLYPH_ROWS     = 13;
    localparam int GLYPH_COLS     = 8;
    localparam int MAX_DIGITS_DEF = 8;
    localparam int PIXEL_BITS     = 16;

    localparam int NUM_W   = 27;
    localparam int COUNT_W = 4;
    localparam int COORD_W = 12;
    localparam int ORIG_W  = 13;
    localparam int PIX_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int DIGIT_W = 4;

    // Pixel mask; a no-op at sixteen bits.
    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'h1 << PIXEL_BITS) - 64'h1);

    // n / 10 == (n * RECIP_10) >> RECIP_SHIFT, exact for n below 2**30.
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_10 = 28'd214748365;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHOWN_NUMBER = 3'd0,
        REG_NUM_DIGITS   = 3'd1,
        REG_ORIGIN_ROW   = 3'd2,
        REG_ORIGIN_COL   = 3'd3,
        REG_INK_VALUE    = 3'd4,
        REG_ERASE_MODE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] num_digits;
        logic [ORIG_W-1:0]  origin_row;
        logic [ORIG_W-1:0]  origin_col;
        logic [PIX_W-1:0]   ink_value;
        logic               erase_mode;
    } ovl_cfg_t;

    localparam logic [7:0] GLYPH_ROM [0:9][0:GLYPH_ROWS-1] = '{
        '{8'h18,8'h3C,8'h42,8'h42,8'h42,8'h42,8'h42,8'h42,8'h42,8'h42,8'h42,8'h3C,8'h18},
        '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
        '{8'h00,8'h38,8'h44,8'h04,8'h04,8'h04,8'h08,8'h10,8'h20,8'h40,8'h40,8'h7C,8'h00},
        '{8'h00,8'h38,8'h04,8'h04,8'h04,8'h08,8'h10,8'h08,8'h04,8'h04,8'h44,8'h38,8'h00},
        '{8'h00,8'h44,8'h44,8'h44,8'h44,8'h44,8'h7C,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00},
        '{8'h00,8'h3E,8'h20,8'h20,8'h20,8'h3E,8'h02,8'h02,8'h02,8'h02,8'h02,8'h3E,8'h00},
        '{8'h00,8'h3C,8'h20,8'h20,8'h20,8'h20,8'h3E,8'h22,8'h22,8'h22,8'h22,8'h3E,8'h00},
        '{8'h00,8'h7C,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00},
        '{8'h00,8'h7E,8'h42,8'h42,8'h42,8'h42,8'h7E,8'h42,8'h42,8'h42,8'h42,8'h7E,8'h00},
        '{8'h00,8'h3E,8'h42,8'h42,8'h42,8'h42,8'h7E,8'h02,8'h02,8'h02,8'h02,8'h02,8'h00}
    };

    // One glyph row; codes outside the table read as blank.
    function automatic logic [7:0] glyph_row(input logic [DIGIT_W-1:0] digit,
                                             input logic [3:0] row);
        logic [7:0] bits;
        bits = 8'h00;
        if (digit <= 4'd9 && row < 4'(GLYPH_ROWS))
        begin
            bits = GLYPH_ROM[digit][row];
        end
        return bits;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ddto_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddto_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ddto_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ddto_digit_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddto_digit_conv
// Splits the shown number into decimal digits, one per cycle, and writes
// them into the digit memory indexed by decimal place.
// ----------------------------------------------------------------------------
module ddto_digit_conv #(
    parameter int MAX_DIGITS = ddto_pkg::MAX_DIGITS_DEF,
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [ddto_pkg::NUM_W-1:0]  number,
    output logic                             busy,
    output logic                             dig_we,
    output logic      [AW-1:0]               dig_addr,
    output logic      [ddto_pkg::DIGIT_W-1:0] dig_data
);
    import ddto_pkg::*;

    localparam int PROD_W = NUM_W + RECIP_W;

    logic              busy_reg, busy_next;
    logic [AW-1:0]     place_reg, place_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  quot_x10;

    always_comb
    begin
        prod     = PROD_W'(rem_reg) * PROD_W'(RECIP_10);
        quot     = NUM_W'(prod >> RECIP_SHIFT);
        quot_x10 = (quot << 3) + (quot << 1);
        dig_data = DIGIT_W'(rem_reg - quot_x10);
        dig_we   = busy_reg;
        dig_addr = place_reg;
        busy     = busy_reg;

        busy_next  = busy_reg;
        place_next = place_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            // restart from the least significant place
            busy_next  = 1'b1;
            place_next = '0;
            rem_next   = number;
        end
        else if (busy_reg)
        begin
            rem_next   = quot;
            place_next = place_reg + AW'(1);
            if (place_reg == AW'(MAX_DIGITS - 1))
            begin
                busy_next  = 1'b0;
                place_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // fill the memory with the digits of zero after reset
            busy_reg  <= 1'b1;
            place_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            place_reg <= place_next;
            rem_reg   <= rem_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ddto_render.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddto_render
// Two-stage pixel path: box test and digit address, then glyph and blend.
// ----------------------------------------------------------------------------
module ddto_render #(
    parameter int MAX_DIGITS = ddto_pkg::MAX_DIGITS_DEF,
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire ddto_pkg::ovl_cfg_t            cfg,
    input  wire logic [ddto_pkg::COORD_W-1:0]  pixel_row,
    input  wire logic [ddto_pkg::COORD_W-1:0]  pixel_col,
    input  wire logic [ddto_pkg::PIX_W-1:0]    pixel_in,
    output logic      [AW-1:0]                 dig_raddr,
    input  wire logic [ddto_pkg::DIGIT_W-1:0]  dig_rdata,
    output logic                               done,
    output logic      [ddto_pkg::PIX_W-1:0]    pixel_out
);
    import ddto_pkg::*;

    localparam int DW = ORIG_W + 1;

    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] dc;
    logic [COUNT_W-1:0]   count_sat;
    logic [COUNT_W-1:0]   place;
    logic                 in_box;

    logic                 s1_valid_reg;
    logic                 s1_in_box_reg;
    logic [3:0]           s1_row_reg;
    logic [2:0]           s1_col_reg;
    logic [PIX_W-1:0]     s1_pix_reg;

    logic [7:0]           bits;
    logic                 set;
    logic [PIX_W-1:0]     ink;
    logic [PIX_W-1:0]     pix_next;

    logic                 done_reg;
    logic [PIX_W-1:0]     pixel_out_reg;

    always_comb
    begin
        count_sat = (cfg.num_digits > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                            : cfg.num_digits;
        dr = $signed({2'b00, pixel_row}) - $signed({cfg.origin_row[ORIG_W-1], cfg.origin_row});
        dc = $signed({2'b00, pixel_col}) - $signed({cfg.origin_col[ORIG_W-1], cfg.origin_col});
        in_box = (count_sat != '0)
              && !dr[DW-1] && (dr[DW-2:0] < (DW-1)'(GLYPH_ROWS))
              && !dc[DW-1] && (dc[DW-2:0] < (DW-1)'({count_sat, 3'b000}));
        // decimal place of the glyph under this column, most significant first
        place     = count_sat - COUNT_W'(1) - COUNT_W'(dc[DW-2:3]);
        dig_raddr = AW'(place);
    end

    always_comb
    begin
        bits = glyph_row(dig_rdata, s1_row_reg);
        set  = bits[3'd7 - s1_col_reg];
        ink  = set ? cfg.ink_value : '0;
        if (!s1_in_box_reg)
        begin
            pix_next = s1_pix_reg;
        end
        else if (cfg.erase_mode)
        begin
            pix_next = ink;
        end
        else
        begin
            pix_next = (s1_pix_reg >> 1) | ink;
        end
        done      = done_reg;
        pixel_out = pixel_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_box_reg <= in_box;
            s1_row_reg    <= dr[3:0];
            s1_col_reg    <= dc[2:0];
            s1_pix_reg    <= pixel_in;
        end
        if (s1_valid_reg)
        begin
            pixel_out_reg <= pix_next & PIX_MASK;
        end
    end

endmodule
`default_nettype wire

>>> rtl/decimal_digit_text_overlay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_text_overlay
// Draws the low decimal digits of a configured number into a pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock whenever busy is low: a request is accepted at a
// rising edge with start high and busy low, and its result passes the stage
// one and output registers to pixel_out with done high for exactly one cycle.
// The receiver cannot stall the output, so it must take every done cycle.
// The box test and the digit memory address are formed ahead of the stage
// one registers; the digit memory read, glyph and blend ahead of the output
// register. Busy is high after reset and after every write of shown_number
// while the number is split one decimal digit per cycle by a divide-by-ten
// multiplier into the digit memory. Other register writes take effect at once.
// Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module decimal_digit_text_overlay #(
    parameter int MAX_DIGITS = ddto_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [ddto_pkg::COORD_W-1:0]     pixel_row,
    input  wire logic [ddto_pkg::COORD_W-1:0]     pixel_col,
    input  wire logic [ddto_pkg::PIX_W-1:0]       pixel_in,
    output logic                                  done,
    output logic      [ddto_pkg::PIX_W-1:0]       pixel_out,
    input  wire logic                             cfg_we,
    input  wire logic [ddto_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ddto_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ddto_pkg::*;

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    ovl_cfg_t         cfg_reg;
    logic             load_num;
    logic             accept;

    logic             dig_we;
    logic [AW-1:0]    dig_waddr;
    logic [DIGIT_W-1:0] dig_wdata;
    logic [AW-1:0]    dig_raddr;
    logic [DIGIT_W-1:0] dig_rdata;

    // Hold the drawing registers; a write of the number goes to the splitter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_digits  <= COUNT_W'(1);
            cfg_reg.origin_row  <= '0;
            cfg_reg.origin_col  <= '0;
            cfg_reg.ink_value   <= '1;
            cfg_reg.erase_mode  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_DIGITS:  cfg_reg.num_digits  <= cfg_data[COUNT_W-1:0];
                REG_ORIGIN_ROW:  cfg_reg.origin_row  <= cfg_data[ORIG_W-1:0];
                REG_ORIGIN_COL:  cfg_reg.origin_col  <= cfg_data[ORIG_W-1:0];
                REG_INK_VALUE:   cfg_reg.ink_value   <= cfg_data[PIX_W-1:0];
                REG_ERASE_MODE:  cfg_reg.erase_mode  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign load_num = cfg_we && (cfg_index == REG_SHOWN_NUMBER);
    assign accept   = start && !busy;

    // Split the number into digits, least significant place first.
    ddto_digit_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load_num),
        .number   (cfg_data[NUM_W-1:0]),
        .busy     (busy),
        .dig_we   (dig_we),
        .dig_addr (dig_waddr),
        .dig_data (dig_wdata)
    );

    // Digit memory, one entry per decimal place.
    ddto_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (dig_we),
        .waddr (dig_waddr),
        .wdata (dig_wdata),
        .raddr (dig_raddr),
        .rdata (dig_rdata)
    );

    // Pixel path: address the digit, then draw the glyph.
    ddto_render #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_render (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg       (cfg_reg),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .pixel_in  (pixel_in),
        .dig_raddr (dig_raddr),
        .dig_rdata (dig_rdata),
        .done      (done),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

>>> bench/ddto_overlay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddto_overlay_checker
// Watches the request, result and register channels of the digit overlay,
// predicts every output pixel and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module ddto_overlay_checker
    import ddto_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [COORD_W-1:0]    pixel_row,
    input  logic [COORD_W-1:0]    pixel_col,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  done,
    input  logic [PIX_W-1:0]      pixel_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int DIGIT_LIMIT = 8;

    // Register mirror.
    logic [NUM_W-1:0]   number_q;
    logic [COUNT_W-1:0] digits_q;
    logic [ORIG_W-1:0]  orow_q;
    logic [ORIG_W-1:0]  ocol_q;
    logic [PIX_W-1:0]   ink_q;
    logic               erase_q;

    logic [PIX_W-1:0]   expected_pixels [$];

    // Own copy of the 8x13 font, rows packed top first, bit 7 leftmost.
    function automatic logic [7:0] font_row(input int digit, input int row);
        logic [103:0] rows;
        case (digit)
            0: rows = 104'h183C4242424242424242423C18;
            1: rows = 104'h00080808080808080808080800;
            2: rows = 104'h00384404040408102040407C00;
            3: rows = 104'h00380404040810080404443800;
            4: rows = 104'h0044444444447C040404040400;
            5: rows = 104'h003E2020203E02020202023E00;
            6: rows = 104'h003C202020203E222222223E00;
            7: rows = 104'h007C0404040404040404040400;
            8: rows = 104'h007E424242427E424242427E00;
            default: rows = 104'h003E424242427E020202020200;
        endcase
        return rows[103 - 8*row -: 8];
    endfunction

    function automatic logic [PIX_W-1:0] overlay_pixel(input logic [COORD_W-1:0] row,
                                                       input logic [COORD_W-1:0] col,
                                                       input logic [PIX_W-1:0] pix);
        int          cnt;
        int          dr;
        int          dc;
        int          place;
        int unsigned scaled;
        logic [7:0]  bits;
        logic [PIX_W-1:0] ink;
        logic [PIX_W-1:0] result;
        cnt = (int'(digits_q) > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(digits_q);
        dr = int'(row) - int'($signed(orow_q));
        dc = int'(col) - int'($signed(ocol_q));
        result = pix;
        if (cnt > 0 && dr >= 0 && dr < GLYPH_ROWS && dc >= 0 && dc < GLYPH_COLS * cnt)
        begin
            place = cnt - 1 - dc / GLYPH_COLS;
            scaled = int'(number_q);
            for (int k = 0; k < place; k++)
            begin
                scaled = scaled / 10;
            end
            bits = font_row(int'(scaled % 10), dr);
            ink = bits[GLYPH_COLS - 1 - dc % GLYPH_COLS] ? ink_q : '0;
            result = erase_q ? ink : ((pix >> 1) | ink);
        end
        return result & PIX_MASK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_q    <= '0;
            digits_q    <= COUNT_W'(1);
            orow_q      <= '0;
            ocol_q      <= '0;
            ink_q       <= 16'hFFFF;
            erase_q     <= 1'b0;
            fail_count  <= 0;
            outstanding <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHOWN_NUMBER: number_q <= cfg_data[NUM_W-1:0];
                    REG_NUM_DIGITS:   digits_q <= cfg_data[COUNT_W-1:0];
                    REG_ORIGIN_ROW:   orow_q   <= cfg_data[ORIG_W-1:0];
                    REG_ORIGIN_COL:   ocol_q   <= cfg_data[ORIG_W-1:0];
                    REG_INK_VALUE:    ink_q    <= cfg_data[PIX_W-1:0];
                    REG_ERASE_MODE:   erase_q  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                expected_pixels.push_back(overlay_pixel(pixel_row, pixel_col, pixel_in));
            end
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: pixel_out with no request pending: expected none, got %h",
                             $realtime, pixel_out);
                    fail_count <= fail_count + 1;
                end
                else if (pixel_out !== expected_pixels[0])
                begin
                    $display("%0t: pixel_out mismatch: expected %h, got %h",
                             $realtime, expected_pixels[0], pixel_out);
                    fail_count <= fail_count + 1;
                    void'(expected_pixels.pop_front());
                end
                else
                begin
                    void'(expected_pixels.pop_front());
                end
            end
            outstanding <= expected_pixels.size();
        end
    end

endmodule

>>> bench/tb_decimal_digit_text_overlay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_digit_text_overlay
// Drives pixel requests and register writes into the digit overlay and gives
// the verdict; prediction and comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module tb_decimal_digit_text_overlay;
    import ddto_pkg::*;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = 3'd7;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 15;
    localparam int PHASE_PIXELS  = 30;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    pixel_row = '0;
    logic [COORD_W-1:0]    pixel_col = '0;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  done;
    logic [PIX_W-1:0]      pixel_out;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;

    // Idle gaps between requests; cleared for a long back-to-back stretch.
    bit idle_enabled = 1'b1;

    // Stimulus-side copy of where the text box sits, used only to aim pixels.
    logic [ORIG_W-1:0]  aim_row = '0;
    logic [ORIG_W-1:0]  aim_col = '0;
    logic [COUNT_W-1:0] aim_count = COUNT_W'(1);

    decimal_digit_text_overlay i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ddto_overlay_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .pixel_in    (pixel_in),
        .done        (done),
        .pixel_out   (pixel_out),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Issue one pixel request. Start stays high across back-to-back requests;
    // it only drops when an idle gap is taken before this one.
    task automatic send_pixel(input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col,
                              input logic [PIX_W-1:0] pix);
        int gap;
        if (idle_enabled && $urandom_range(99) < 10)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        pixel_row <= row;
        pixel_col <= col;
        pixel_in  <= pix;
        // Hold the request until an edge sees busy low.
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Drop start and wait until every requested pixel has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Load a full setting. Write the number last: it starts the digit split,
    // and the requests that follow wait out busy by themselves.
    task automatic set_overlay(input logic [NUM_W-1:0] num,
                               input logic [COUNT_W-1:0] cnt,
                               input logic [ORIG_W-1:0] orow,
                               input logic [ORIG_W-1:0] ocol,
                               input logic [PIX_W-1:0] ink,
                               input logic erase);
        drain();
        write_reg(REG_NUM_DIGITS, CFG_DATA_W'(cnt));
        write_reg(REG_ORIGIN_ROW, CFG_DATA_W'(orow));
        write_reg(REG_ORIGIN_COL, CFG_DATA_W'(ocol));
        write_reg(REG_INK_VALUE, CFG_DATA_W'(ink));
        write_reg(REG_ERASE_MODE, CFG_DATA_W'(erase));
        write_reg(REG_SHOWN_NUMBER, CFG_DATA_W'(num));
        aim_row   = orow;
        aim_col   = ocol;
        aim_count = cnt;
    endtask

    function automatic logic [ORIG_W-1:0] pick_origin();
        logic [ORIG_W-1:0] value;
        case ($urandom_range(9))
            0: value = ORIG_W'(-4096);
            1: value = ORIG_W'(4095);
            2: value = ORIG_W'(-int'($urandom_range(1, 12)));
            3: value = ORIG_W'($urandom);
            4: value = ORIG_W'(4095 - int'($urandom_range(20)));
            default: value = ORIG_W'($urandom_range(0, 4080));
        endcase
        return value;
    endfunction

    task automatic randomize_overlay();
        logic [NUM_W-1:0]   num;
        logic [COUNT_W-1:0] cnt;
        logic [PIX_W-1:0]   ink;
        case ($urandom_range(7))
            0: num = '0;
            1: num = NUM_W'(99999999);
            2: num = '1;
            3: num = NUM_W'($urandom);
            default: num = NUM_W'($urandom_range(0, 99999999));
        endcase
        cnt = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(0, 15))
                                       : COUNT_W'($urandom_range(1, 8));
        case ($urandom_range(4))
            0: ink = '0;
            1: ink = '1;
            default: ink = PIX_W'($urandom);
        endcase
        set_overlay(num, cnt, pick_origin(), pick_origin(), ink, 1'($urandom));
        // Poke an unused index now and then; it must change nothing.
        if ($urandom_range(3) == 0)
        begin
            write_reg($urandom_range(1) ? SPARE_REG_A : SPARE_REG_B, CFG_DATA_W'($urandom));
        end
    endtask

    // Mostly aim at the text box and its border; otherwise any coordinate.
    task automatic send_random_pixel();
        int span;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        span = (aim_count > 4'd8) ? 8 : ((aim_count == 0) ? 1 : int'(aim_count));
        if ($urandom_range(9) < 7)
        begin
            row = COORD_W'(int'($signed(aim_row)) + int'($urandom_range(16)) - 2);
            col = COORD_W'(int'($signed(aim_col)) + int'($urandom_range(8 * span + 5)) - 3);
        end
        else
        begin
            row = COORD_W'($urandom);
            col = COORD_W'($urandom);
        end
        send_pixel(row, col, PIX_W'($urandom));
    endtask

    // Watchdog: end the run if nothing moves for too long.
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        // Hold reset, then release it on a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: one digit zero at the image corner, blend, full ink.
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd3, 16'h0000);
        send_pixel(12'd12, 12'd7, 16'h8001);
        send_pixel(12'd13, 12'd0, 16'h1234);
        send_pixel(12'd0, 12'd8, 16'hABCD);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);

        // Eight digits in blend mode, corners and just-outside neighbors.
        set_overlay(NUM_W'(12345678), 4'd8, 13'd100, 13'd200, 16'h00F0, 1'b0);
        send_pixel(12'd100, 12'd200, 16'h5A5A);
        send_pixel(12'd106, 12'd215, 16'hFFFF);
        send_pixel(12'd112, 12'd263, 16'h0F0F);
        send_pixel(12'd113, 12'd263, 16'h1111);
        send_pixel(12'd100, 12'd264, 16'h2222);
        send_pixel(12'd99, 12'd230, 16'h3333);

        // Erase mode: box pixels become ink or zero.
        set_overlay(NUM_W'(90817263), 4'd8, 13'd0, 13'd0, 16'hFFFF, 1'b1);
        send_pixel(12'd6, 12'd0, 16'hFFFF);
        send_pixel(12'd6, 12'd1, 16'h7777);
        send_pixel(12'd12, 12'd63, 16'h0001);
        send_pixel(12'd5, 12'd30, 16'hC3C3);

        // Zero digit count: no box at all, everything passes through.
        set_overlay(NUM_W'(5), 4'd0, 13'd0, 13'd0, 16'hFFFF, 1'b1);
        send_pixel(12'd0, 12'd0, 16'h5555);
        send_pixel(12'd6, 12'd3, 16'hAAAA);

        // Count above the digit limit, number past eight digits, negative
        // origin, and writes to unused indexes that must be dropped.
        drain();
        write_reg(SPARE_REG_A, '1);
        write_reg(SPARE_REG_B, '0);
        set_overlay('1, 4'd15, ORIG_W'(-5), ORIG_W'(-10), 16'h8000, 1'b0);
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd7, 12'd40, 16'h0000);
        send_pixel(12'd7, 12'd54, 16'h8888);

        // Origin at the far corner of the image.
        set_overlay(NUM_W'(7), 4'd1, 13'd4095, 13'd4095, 16'h0001, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);

        // Random phases; the middle three run back to back with no gaps.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            idle_enabled = (phase < 6 || phase > 8);
            randomize_overlay();
            for (int k = 0; k < PHASE_PIXELS; k++)
            begin
                send_random_pixel();
            end
        end

        // Drain, then allow the pipeline to settle.
        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
